// File: hw/rtl/pip_pkg.sv
// Shared types and constants of the point-in-polygon winding block.
package pip_pkg;

  // Coordinate and result widths
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DET_W     = PROD_W + 1;
  localparam int CTOL_W    = 16;
  localparam int DTOL_W    = 32;
  localparam int WIND_W    = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int OUT_DATA_W = 16;

  // Winding count saturates at +-MAX_EDGES/2
  localparam int MAX_EDGES = 1024;
  localparam logic signed [WIND_W-1:0] WIND_LIMIT = WIND_W'(MAX_EDGES / 2);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_COORD_TOL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DET_TOL   = 1'd1;

  // Early classification of one edge, before the determinant is known
  typedef enum logic [1:0] {
    EDGE_NONE,
    EDGE_BND,
    EDGE_WIND,
    EDGE_DET
  } pip_code_t;

  // Outcome of one edge, handed to the accumulator
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic bnd;
    logic wind;
    logic up;
  } pip_evt_t;

endpackage

// File: hw/rtl/pip_edge.sv
// Edge geometry pipeline: differences, vertex tests, products, determinant, outcome.
module pip_edge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   req_vld,
  input  logic signed [pip_pkg::COORD_W-1:0]     start_x,
  input  logic signed [pip_pkg::COORD_W-1:0]     start_y,
  input  logic signed [pip_pkg::COORD_W-1:0]     end_x,
  input  logic signed [pip_pkg::COORD_W-1:0]     end_y,
  input  logic signed [pip_pkg::COORD_W-1:0]     query_x,
  input  logic signed [pip_pkg::COORD_W-1:0]     query_y,
  input  logic                                   first_edge,
  input  logic                                   last_edge,
  input  logic [pip_pkg::CTOL_W-1:0]             coord_tol,
  input  logic [pip_pkg::DTOL_W-1:0]             det_tol,
  output pip_pkg::pip_evt_t                      evt
);

  localparam int CW = pip_pkg::COORD_W;
  localparam int DW = pip_pkg::DIFF_W;
  localparam int PW = pip_pkg::PROD_W;
  localparam int TW = pip_pkg::DET_W;

  // |d| <= tol on a coordinate difference
  function automatic logic near(input logic signed [DW-1:0] d,
                                input logic [pip_pkg::CTOL_W-1:0] tol);
    logic signed [DW:0] t;
    logic signed [DW:0] dd;
    t  = $signed({{(DW + 1 - pip_pkg::CTOL_W){1'b0}}, tol});
    dd = {d[DW-1], d};
    near = (dd <= t) && (dd >= -t);
  endfunction

  // Stage 1: input register
  logic                  v1_r;
  logic signed [CW-1:0]  x0_r, y0_r, x1_r, y1_r, rx_r, ry_r;
  logic                  f1_r, l1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= req_vld;
    end
    if (adv) begin
      x0_r <= start_x;
      y0_r <= start_y;
      x1_r <= end_x;
      y1_r <= end_y;
      rx_r <= query_x;
      ry_r <= query_y;
      f1_r <= first_edge;
      l1_r <= last_edge;
    end
  end

  // Differences to the query point and early classification
  logic signed [DW-1:0] dx0, dy0, dx1, dy1;
  logic                 a_ge, b_gt, up;
  pip_pkg::pip_code_t   code_nxt;

  assign dx0 = DW'(x0_r) - DW'(rx_r);
  assign dy0 = DW'(y0_r) - DW'(ry_r);
  assign dx1 = DW'(x1_r) - DW'(rx_r);
  assign dy1 = DW'(y1_r) - DW'(ry_r);
  assign a_ge = !dx0[DW-1];
  assign b_gt = !dx1[DW-1] && (dx1 != '0);
  assign up   = y1_r > y0_r;

  always_comb begin
    if (f1_r && near(dx0, coord_tol) && near(dy0, coord_tol)) begin
      code_nxt = pip_pkg::EDGE_BND;
    end else if (near(dy1, coord_tol) && near(dx1, coord_tol)) begin
      code_nxt = pip_pkg::EDGE_BND;
    end else if (near(dy1, coord_tol) && near(dy0, coord_tol) &&
                 (b_gt == dx0[DW-1])) begin
      code_nxt = pip_pkg::EDGE_BND;
    end else if (dy0[DW-1] == dy1[DW-1]) begin
      code_nxt = pip_pkg::EDGE_NONE;
    end else if (a_ge && b_gt) begin
      code_nxt = pip_pkg::EDGE_WIND;
    end else if (!a_ge && !b_gt) begin
      code_nxt = pip_pkg::EDGE_NONE;
    end else begin
      code_nxt = pip_pkg::EDGE_DET;
    end
  end

  // Stage 2: differences and classification
  logic                 v2_r, f2_r, l2_r, up2_r;
  pip_pkg::pip_code_t   code2_r;
  logic signed [DW-1:0] dx0_r, dy0_r, dx1_r, dy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      f2_r    <= f1_r;
      l2_r    <= l1_r;
      up2_r   <= up;
      code2_r <= code_nxt;
      dx0_r   <= dx0;
      dy0_r   <= dy0;
      dx1_r   <= dx1;
      dy1_r   <= dy1;
    end
  end

  // Stage 3: the two cross products
  logic                 v3_r, f3_r, l3_r, up3_r;
  pip_pkg::pip_code_t   code3_r;
  logic signed [PW-1:0] p0_r, p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      f3_r    <= f2_r;
      l3_r    <= l2_r;
      up3_r   <= up2_r;
      code3_r <= code2_r;
      p0_r    <= dx0_r * dy1_r;
      p1_r    <= dx1_r * dy0_r;
    end
  end

  // Stage 4: determinant
  logic                 v4_r, f4_r, l4_r, up4_r;
  pip_pkg::pip_code_t   code4_r;
  logic signed [TW-1:0] det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      f4_r    <= f3_r;
      l4_r    <= l3_r;
      up4_r   <= up3_r;
      code4_r <= code3_r;
      det_r   <= TW'(p0_r) - TW'(p1_r);
    end
  end

  // Final outcome: point on the edge, crossing, or nothing
  logic signed [TW-1:0] dtol_s;
  logic                 det_zero;

  assign dtol_s   = $signed({{(TW - pip_pkg::DTOL_W){1'b0}}, det_tol});
  assign det_zero = (det_r <= dtol_s) && (det_r >= -dtol_s);

  always_comb begin
    evt       = '0;
    evt.vld   = v4_r;
    evt.first = f4_r;
    evt.last  = l4_r;
    evt.up    = up4_r;
    case (code4_r)
      pip_pkg::EDGE_BND:  evt.bnd = 1'b1;
      pip_pkg::EDGE_WIND: evt.wind = 1'b1;
      pip_pkg::EDGE_DET: begin
        if (det_zero) begin
          evt.bnd = 1'b1;
        end else begin
          evt.wind = ((det_r > 0) == up4_r);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/pip_accum.sv
// Winding count and boundary flag accumulator with the result register.
module pip_accum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  pip_pkg::pip_evt_t                    evt,
  input  logic                                 out_ready,
  output logic                                 out_vld,
  output logic                                 inside_res,
  output logic                                 on_boundary,
  output logic signed [pip_pkg::WIND_W-1:0]    winding
);

  localparam int WW = pip_pkg::WIND_W;

  logic signed [WW-1:0] wind_r, wind_nxt, wind_base;
  logic                 bnd_r, bnd_nxt, bnd_base;
  logic                 out_vld_r, inside_r, onb_r;
  logic signed [WW-1:0] out_wind_r;
  logic                 take;

  assign take = adv && evt.vld;

  // Per-edge update: first mark clears, latched boundary freezes the count
  always_comb begin
    wind_base = evt.first ? '0 : wind_r;
    bnd_base  = evt.first ? 1'b0 : bnd_r;
    wind_nxt  = wind_base;
    bnd_nxt   = bnd_base;
    if (!bnd_base) begin
      if (evt.bnd) begin
        bnd_nxt = 1'b1;
      end else if (evt.wind) begin
        if (evt.up) begin
          wind_nxt = (wind_base == pip_pkg::WIND_LIMIT) ? wind_base : wind_base + WW'(1);
        end else begin
          wind_nxt = (wind_base == -pip_pkg::WIND_LIMIT) ? wind_base : wind_base - WW'(1);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_r <= '0;
      bnd_r  <= 1'b0;
    end else if (take) begin
      wind_r <= wind_nxt;
      bnd_r  <= bnd_nxt;
    end
  end

  // Result register, loaded on the last edge of a polygon
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take && evt.last) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (take && evt.last) begin
      inside_r   <= (wind_nxt != '0) && !bnd_nxt;
      onb_r      <= bnd_nxt;
      out_wind_r <= wind_nxt;
    end
  end

  assign out_vld     = out_vld_r;
  assign inside_res  = inside_r;
  assign on_boundary = onb_r;
  assign winding     = out_wind_r;

`ifndef NO_ASSERTIONS
  a_wind_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wind_r <= pip_pkg::WIND_LIMIT) && (wind_r >= -pip_pkg::WIND_LIMIT))
    else $error("winding count outside saturation range");

  a_bnd_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (take && bnd_r && !evt.first) |=> ($stable(wind_r) && bnd_r))
    else $error("winding count changed after boundary latched");

  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (take && evt.last) |=> out_vld_r)
    else $error("last edge did not produce a result");

  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    evt.vld |-> !(evt.bnd && evt.wind))
    else $error("edge flagged both boundary and crossing");
`endif

endmodule

// File: hw/rtl/point_in_polygon_winding_top.sv
// Top level of the point-in-polygon winding-number block.
// Takes one polygon edge per cycle, unless stalled, with the query point and first/last marks,
// and after the last edge returns inside, on-boundary and the saturated winding
// count. Edges pass a five-stage pipeline (input register, differences,
// two 25x25 products, determinant, accumulate), so a request can be accepted
// before earlier edges are through. The pipeline stalls only when a last edge
// reaches the accumulator while the previous result is still waiting to be
// taken; edges that are not last keep flowing meanwhile. Tolerances are to be
// written over the cfg port only while idle; the block does not enforce this.
module point_in_polygon_winding_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Edge requests
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72],
  // query_x[119:96], query_y[143:120]
  input  logic [pip_pkg::IN_DATA_W-1:0]         in_tdata,
  // first_edge[0]
  input  logic                                  in_tuser,
  input  logic                                  in_tlast,
  // Results
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // inside_res[0], on_boundary[1], winding[12:2], zero[15:13]
  output logic [pip_pkg::OUT_DATA_W-1:0]        out_tdata,
  // Configuration
  input  logic                                  cfg_wr_en,
  input  logic [pip_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [pip_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CW = pip_pkg::COORD_W;

  logic [pip_pkg::CTOL_W-1:0] coord_tol_r;
  logic [pip_pkg::DTOL_W-1:0] det_tol_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_tol_r <= pip_pkg::CTOL_W'(1);
      det_tol_r   <= pip_pkg::DTOL_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pip_pkg::REG_COORD_TOL: coord_tol_r <= cfg_wdata[pip_pkg::CTOL_W-1:0];
        pip_pkg::REG_DET_TOL:   det_tol_r   <= cfg_wdata[pip_pkg::DTOL_W-1:0];
        default: ;
      endcase
    end
  end

  pip_pkg::pip_evt_t evt;
  logic              adv;
  logic              res_vld;
  logic              inside_res, on_boundary;
  logic signed [pip_pkg::WIND_W-1:0] winding;

  // Hold the pipeline only when a result is due and the result register is full
  assign adv       = !(evt.vld && evt.last && res_vld && !out_tready);
  assign in_tready = adv;

  pip_edge u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .req_vld    (in_tvalid),
    .start_x    (in_tdata[CW-1:0]),
    .start_y    (in_tdata[2*CW-1:CW]),
    .end_x      (in_tdata[3*CW-1:2*CW]),
    .end_y      (in_tdata[4*CW-1:3*CW]),
    .query_x    (in_tdata[5*CW-1:4*CW]),
    .query_y    (in_tdata[6*CW-1:5*CW]),
    .first_edge (in_tuser),
    .last_edge  (in_tlast),
    .coord_tol  (coord_tol_r),
    .det_tol    (det_tol_r),
    .evt        (evt)
  );

  pip_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .evt         (evt),
    .out_ready   (out_tready),
    .out_vld     (res_vld),
    .inside_res  (inside_res),
    .on_boundary (on_boundary),
    .winding     (winding)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = {3'b000, winding, on_boundary, inside_res};

endmodule
